// ----- src/veto_energy_histogram_assert.svh -----
// Assertion macros used by the checker of this block.
`ifndef VETO_ENERGY_HISTOGRAM_ASSERT_SVH
`define VETO_ENERGY_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define VEH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define VEH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/veh_pkg.sv -----
package veh_pkg;

   localparam int SAMPLE_W       = 24;
   localparam int SUM_W          = 27;
   localparam int POS_W          = 5;
   localparam int IDX_W          = 5;
   localparam int HIST_DEPTH     = 32;
   localparam int OUT_W          = 32;
   localparam int NUM_BINS_DEF   = 32;
   localparam int COUNT_BITS_DEF = 32;

   localparam logic [POS_W-1:0] LAST_POS = 5'd17;
   localparam logic [POS_W-1:0] SPLIT_POS = 5'd16;

   localparam logic signed [SUM_W-1:0] BIN_EDGE [HIST_DEPTH+1] = '{
      27'sd1000, 27'sd1100, 27'sd1200, 27'sd1300, 27'sd1400, 27'sd1500,
      27'sd1600, 27'sd1700, 27'sd1800, 27'sd1900, 27'sd2000, 27'sd2100,
      27'sd2210, 27'sd2320, 27'sd2440, 27'sd2560, 27'sd2690, 27'sd2830,
      27'sd2970, 27'sd3120, 27'sd3280, 27'sd3450, 27'sd3620, 27'sd3810,
      27'sd4000, 27'sd4200, 27'sd4500, 27'sd4800, 27'sd5200, 27'sd5600,
      27'sd6000, 27'sd6500, 27'sd7000
   };

   typedef struct packed {
      logic             binned;
      logic [IDX_W-1:0] idx;
      logic             outer;
      logic             back;
   } event_type;

endpackage

// ----- src/veh_binner.sv -----
module veh_binner
   import veh_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEF
) (
   input  logic signed [SUM_W-1:0] sum,
   output logic                    hit,
   output logic [IDX_W-1:0]        idx
);

   logic [HIST_DEPTH-1:0] hit_vec;

   always_comb begin
      for (int k = 0; k < HIST_DEPTH; k++) begin
         hit_vec[k] = (k < NUM_BINS) && (sum >= BIN_EDGE[k]) && (sum < BIN_EDGE[k+1]);
      end
   end

   always_comb begin
      idx = '0;
      for (int k = 0; k < HIST_DEPTH; k++) begin
         idx = idx | ({IDX_W{hit_vec[k]}} & IDX_W'(k));
      end
   end

   assign hit = |hit_vec;

endmodule

// ----- src/veh_accum.sv -----
module veh_accum
   import veh_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_value,
   output logic                       evt_valid,
   input  logic                       evt_ready,
   output event_type                  evt
);

   logic                       a_valid_ff, a_valid_in;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [POS_W-1:0]           position_ff, position_in;
   logic signed [SUM_W-1:0]    singles_ff, singles_in;
   logic signed [SUM_W-1:0]    doubles_ff, doubles_in;
   logic signed [SUM_W-1:0]    sample_ext;
   logic signed [SUM_W-1:0]    final_singles;
   logic                       a_last, a_done, a_free;
   logic                       outer, back, hit;
   logic [IDX_W-1:0]           idx;

   assign a_last    = (position_ff == LAST_POS);
   assign a_done    = a_valid_ff && (!a_last || evt_ready);
   assign a_free    = !a_valid_ff || a_done;
   assign req_stall = !a_free;
   assign a_valid_in = a_free ? req_valid : a_valid_ff;

   assign sample_ext = {{(SUM_W-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};

   always_comb begin
      position_in = position_ff;
      singles_in  = singles_ff;
      doubles_in  = doubles_ff;
      if (a_done) begin
         if (a_last) begin
            position_in = '0;
            singles_in  = '0;
            doubles_in  = '0;
         end else begin
            position_in = position_ff + POS_W'(1);
            if (position_ff[0] && (position_ff < SPLIT_POS)) begin
               singles_in = singles_ff + sample_ext;
            end
            if (!position_ff[0] && (position_ff != '0)) begin
               doubles_in = doubles_ff + sample_ext;
            end
         end
      end
   end

   // drop the singles sum on either veto
   assign outer         = !doubles_ff[SUM_W-1] && (doubles_ff != '0);
   assign back          = !sample_ff[SAMPLE_W-1] && (sample_ff != '0);
   assign final_singles = (outer || back) ? '0 : singles_ff;

   veh_binner #(
      .NUM_BINS (NUM_BINS)
   ) u_binner (
      .sum (final_singles),
      .hit (hit),
      .idx (idx)
   );

   assign evt_valid  = a_valid_ff && a_last;
   assign evt.binned = hit;
   assign evt.idx    = idx;
   assign evt.outer  = outer;
   assign evt.back   = back;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         position_ff <= '0;
         singles_ff  <= '0;
         doubles_ff  <= '0;
      end else begin
         a_valid_ff  <= a_valid_in;
         position_ff <= position_in;
         singles_ff  <= singles_in;
         doubles_ff  <= doubles_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_free && req_valid) begin
         sample_ff <= req_sample_value;
      end
   end

endmodule

// ----- src/veh_hist.sv -----
module veh_hist
   import veh_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             evt_valid,
   output logic             evt_ready,
   input  event_type        evt,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_event_binned,
   output logic [IDX_W-1:0] rsp_bin_index,
   output logic [OUT_W-1:0] rsp_bin_count,
   output logic             rsp_outer_veto,
   output logic             rsp_back_veto,
   output logic [OUT_W-1:0] rsp_outer_total,
   output logic [OUT_W-1:0] rsp_back_total
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   event_type             evt_ff;
   logic                  b_valid_ff, b_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] hist_ff [HIST_DEPTH];
   logic [COUNT_BITS-1:0] outer_ff, back_ff;
   logic [COUNT_BITS-1:0] hist_cur, hist_new, outer_new, back_new;
   logic                  out_free, b_go;

   logic                  binned_ff, outer_veto_ff, back_veto_ff;
   logic [IDX_W-1:0]      bin_index_ff;
   logic [OUT_W-1:0]      bin_count_ff, outer_total_ff, back_total_ff;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign b_go         = b_valid_ff && out_free;
   assign evt_ready    = !b_valid_ff || out_free;
   assign b_valid_in   = evt_ready ? evt_valid : b_valid_ff;
   assign rsp_valid_in = out_free ? b_valid_ff : rsp_valid_ff;

   assign hist_cur  = hist_ff[evt_ff.idx];
   assign hist_new  = (hist_cur == COUNT_MAX) ? hist_cur : hist_cur + COUNT_ONE;
   assign outer_new = (evt_ff.outer && (outer_ff != COUNT_MAX)) ? outer_ff + COUNT_ONE
                                                                : outer_ff;
   assign back_new  = (evt_ff.back && (back_ff != COUNT_MAX)) ? back_ff + COUNT_ONE
                                                              : back_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         outer_ff     <= '0;
         back_ff      <= '0;
         for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_ff[k] <= '0;
         end
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (b_go) begin
            outer_ff <= outer_new;
            back_ff  <= back_new;
            if (evt_ff.binned) begin
               hist_ff[evt_ff.idx] <= hist_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (evt_valid && evt_ready) begin
         evt_ff <= evt;
      end
      if (b_go) begin
         binned_ff      <= evt_ff.binned;
         bin_index_ff   <= evt_ff.binned ? evt_ff.idx : '0;
         bin_count_ff   <= evt_ff.binned ? OUT_W'(hist_new) : '0;
         outer_veto_ff  <= evt_ff.outer;
         back_veto_ff   <= evt_ff.back;
         outer_total_ff <= OUT_W'(outer_new);
         back_total_ff  <= OUT_W'(back_new);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_binned = binned_ff;
   assign rsp_bin_index    = bin_index_ff;
   assign rsp_bin_count    = bin_count_ff;
   assign rsp_outer_veto   = outer_veto_ff;
   assign rsp_back_veto    = back_veto_ff;
   assign rsp_outer_total  = outer_total_ff;
   assign rsp_back_total   = back_total_ff;

endmodule

// ----- src/veto_energy_histogram.sv -----
// Veto-gated singles energy histogram.
// Request channel: one signed 24-bit keV reading per beat on req_sample_value,
// taken when req_valid is high and req_stall is low. Eighteen beats form one
// event; the block tracks the position itself, starting at zero after reset.
// Response channel: one beat per event, issued for the eighteenth reading and
// taken when rsp_valid is high and rsp_stall is low. It carries the bin hit,
// the updated bin count and both veto flags with their running totals.
// Path: the last reading of an event passes the input register, the event
// register and the response register before its response shows. Throughput:
// one reading per cycle while req_stall is low; these registers each advance
// independently, so readings keep flowing while a response waits.
// Stall: a held response keeps its payload; once the event register behind
// it is also full, the last reading of the next event stalls the request side.
// Reset (synchronous): clears position, sums, all 32 bin counters and both
// veto totals at once; no clearing pass is needed.
module veto_energy_histogram
   import veh_pkg::*;
#(
   parameter int NUM_BINS   = NUM_BINS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_event_binned,
   output logic [IDX_W-1:0]           rsp_bin_index,
   output logic [OUT_W-1:0]           rsp_bin_count,
   output logic                       rsp_outer_veto,
   output logic                       rsp_back_veto,
   output logic [OUT_W-1:0]           rsp_outer_total,
   output logic [OUT_W-1:0]           rsp_back_total
);

   logic      evt_valid, evt_ready;
   event_type evt;

   veh_accum #(
      .NUM_BINS (NUM_BINS)
   ) u_accum (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_value (req_sample_value),
      .evt_valid        (evt_valid),
      .evt_ready        (evt_ready),
      .evt              (evt)
   );

   veh_hist #(
      .COUNT_BITS (COUNT_BITS)
   ) u_hist (
      .clock            (clock),
      .reset            (reset),
      .evt_valid        (evt_valid),
      .evt_ready        (evt_ready),
      .evt              (evt),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_binned (rsp_event_binned),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_bin_count    (rsp_bin_count),
      .rsp_outer_veto   (rsp_outer_veto),
      .rsp_back_veto    (rsp_back_veto),
      .rsp_outer_total  (rsp_outer_total),
      .rsp_back_total   (rsp_back_total)
   );

endmodule

// ----- src/veh_checker.sv -----
`include "veto_energy_histogram_assert.svh"

module veh_checker
   import veh_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic                       rsp_event_binned,
   input logic [IDX_W-1:0]           rsp_bin_index,
   input logic [OUT_W-1:0]           rsp_bin_count,
   input logic                       rsp_outer_veto,
   input logic                       rsp_back_veto,
   input logic [OUT_W-1:0]           rsp_outer_total,
   input logic [OUT_W-1:0]           rsp_back_total
);

   `VEH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_bin_count) && $stable(rsp_bin_index)
         && $stable(rsp_outer_total) && $stable(rsp_back_total),
      "response beat changed while stalled")
   `VEH_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid,
      "response valid right after reset")
   `VEH_ASSERT_IMPLY(a_nobin_zero, clock, reset, rsp_valid && !rsp_event_binned,
      (rsp_bin_index == '0) && (rsp_bin_count == '0), "unbinned beat carries bin data")
   `VEH_ASSERT_IMPLY(a_veto_nobin, clock, reset, rsp_valid && (rsp_outer_veto || rsp_back_veto),
      !rsp_event_binned, "vetoed event was binned")
   `VEH_ASSERT_IMPLY(a_req_backpressure, clock, reset, req_stall,
      rsp_valid && rsp_stall, "request stalled without a held response")

endmodule

bind veto_energy_histogram veh_checker u_checker (.*);
